[rtl/skt_pkg.sv]
// Package for the sorted key table: status and action codes, state type, sizes.
`timescale 1ns / 1ps
package skt_pkg;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_LOOKUP = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_LIST   = 3'd4,
        ACT_STATS  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_LIST,
        S_OUT
    } state_t;
endpackage

[rtl/sorted_key_table_top.sv]
// Top level of the sorted key table: memory, sequencer and output register.
//
//  channel | dir | tdata fields (low bit first)                      | tuser/tlast
//  s_axis  | in  | action, key, amount, price_cents (85b in 88)      | -
//  m_axis  | out | status, entry_key, entry_amount, entry_price,     | tlast = last
//          |     | position, entry_count, total_amount, total_value  |
//
// A word is taken, every held entry is scanned through the one memory read port, the read
// and multiply pipeline drains and the first result is issued. Insert then shifts entries
// up to free pos and delete shifts them down over pos, one entry a cycle. List streams one
// entry per cycle while m_axis_tready stays high.
// Reset clears the count; memory contents are undefined until written.
// A stalled output holds its word; no new input word is taken until it leaves.
`timescale 1ns / 1ps
module sorted_key_table_top #(
    parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], key[34:3], amount[59:35], price_cents[84:60], zero fill
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], entry_key[34:3], entry_amount[58:35], entry_price[82:59],
    // position[88:83], entry_count[95:89], total_amount[125:96],
    // total_value[179:126], zero fill
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import skt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [79:0] mem [DEPTH];
    logic [79:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [79:0]   wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic          rv_reg, rv_next;
    logic [2:0]    act_reg, act_next;
    logic [31:0]   key_reg, key_next;
    logic [24:0]   amt_reg, amt_next;
    logic [24:0]   prc_reg, prc_next;
    logic [29:0]   ta_reg, ta_next;
    logic [53:0]   tv_reg, tv_next;
    logic [47:0]   prod_reg, prod_next;
    logic          pv_reg, pv_next;
    logic          ovalid_reg, ovalid_next;
    logic [183:0]  odata_reg, odata_next;
    logic          olast_reg, olast_next;

    logic [31:0] rk;
    logic [23:0] ra, rp;
    logic        bad, ofree, key_lt;
    assign rk = rd_data[31:0];
    assign ra = rd_data[55:32];
    assign rp = rd_data[79:56];
    assign bad = amt_reg[24] | prc_reg[24];
    assign ofree = !ovalid_reg || m_axis_tready;
    assign key_lt = $signed(rk) < $signed(key_reg);

    function automatic logic [183:0] pack(input logic [2:0] st, input logic [31:0] k,
        input logic [23:0] a, input logic [23:0] p, input logic [5:0] ps,
        input logic [6:0] c, input logic [29:0] ta, input logic [53:0] tv);
        pack = {4'd0, tv, ta, c, ps, p, a, k, st};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            rv_reg     <= 1'b0;
            pv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            rv_reg     <= rv_next;
            pv_reg     <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        act_reg   <= act_next;
        key_reg   <= key_next;
        amt_reg   <= amt_next;
        prc_reg   <= prc_next;
        ta_reg    <= ta_next;
        tv_reg    <= tv_next;
        prod_reg  <= prod_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                if (!rv_reg && !pv_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_SHIFT_UP:
            begin
                if (ofree && idx_reg == pos_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_DN:
            begin
                if (ofree && idx_reg >= count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (ofree && rv_reg && pos_reg + 1'b1 >= count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (ofree)
                begin
                    state_next = S_IDLE;
                    if (act_reg == ACT_LIST && count_reg != '0)
                    begin
                        state_next = S_LIST;
                    end
                    else if (act_reg == ACT_INSERT && count_reg < DEPTH_C && !found_reg
                             && !bad)
                    begin
                        state_next = S_SHIFT_UP;
                    end
                    else if (act_reg == ACT_DELETE && found_reg)
                    begin
                        state_next = S_SHIFT_DN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        amt_next    = amt_reg;
        prc_next    = prc_reg;
        ta_next     = ta_reg;
        tv_next     = tv_reg;
        prod_next   = prod_reg;
        pv_next     = 1'b0;
        rv_next     = 1'b0;
        count_next  = count_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;
        s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

        // Scan results arrive in the cycle after each read.
        if (rv_reg && (state_reg == S_SCAN || state_reg == S_SCAN_WAIT))
        begin
            if (rk == key_reg && !found_reg)
            begin
                found_next = 1'b1;
                pos_next   = idx_reg - 1'b1;
                odata_next[82:3] = rd_data;
            end
            if (act_reg == ACT_INSERT && key_lt)
            begin
                pos_next = idx_reg;
            end
            ta_next   = ta_reg + 30'(ra);
            prod_next = ra * rp;
            pv_next   = 1'b1;
        end
        if (pv_reg)
        begin
            tv_next = tv_reg + 54'(prod_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    act_next   = s_axis_tdata[2:0];
                    key_next   = s_axis_tdata[34:3];
                    amt_next   = s_axis_tdata[59:35];
                    prc_next   = s_axis_tdata[84:60];
                    idx_next   = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    ta_next    = '0;
                    tv_next    = '0;
                    odata_next = '0;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_addr  = idx_reg[AW-1:0];
                    rv_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN_WAIT:
            begin
            end
            S_OUT:
            begin
                if (ofree)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b1;
                    odata_next  = pack(ST_INVALID, '0, '0, '0, '0, 7'(count_reg), '0, '0);
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            if (count_reg >= DEPTH_C)
                                odata_next[2:0] = ST_FULL;
                            else if (found_reg)
                                odata_next[2:0] = ST_DUP;
                            else if (bad)
                                odata_next[2:0] = ST_INVALID;
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                odata_next = pack(ST_OK, key_reg, amt_reg[23:0], prc_reg[23:0],
                                    6'(pos_reg), 7'(count_reg + 1'b1), '0, '0);
                                // Shift from the top entry down to pos.
                                idx_next = count_reg;
                                rd_addr  = AW'(count_reg - 1'b1);
                            end
                        end
                        ACT_LOOKUP, ACT_UPDATE, ACT_DELETE:
                        begin
                            if (!found_reg)
                                odata_next[2:0] = ST_NOTFOUND;
                            else if (act_reg == ACT_UPDATE && bad)
                                odata_next[2:0] = ST_INVALID;
                            else
                            begin
                                // Reports the scanned entry; update reports new values.
                                odata_next[82:3]  = odata_reg[82:3];
                                odata_next[2:0]   = ST_OK;
                                odata_next[88:83] = 6'(pos_reg);
                                if (act_reg == ACT_UPDATE)
                                begin
                                    odata_next[82:35] = {prc_reg[23:0], amt_reg[23:0]};
                                    wr_en   = 1'b1;
                                    wr_addr = pos_reg[AW-1:0];
                                    wr_data = {prc_reg[23:0], amt_reg[23:0], key_reg};
                                end
                                if (act_reg == ACT_DELETE)
                                begin
                                    count_next = count_reg - 1'b1;
                                    odata_next[95:89] = 7'(count_reg - 1'b1);
                                    idx_next = pos_reg;
                                    rd_addr  = AW'(pos_reg + 1'b1);
                                end
                            end
                        end
                        ACT_LIST:
                        begin
                            if (count_reg == '0)
                                odata_next[2:0] = ST_EMPTY;
                            else
                            begin
                                ovalid_next = 1'b0;
                                pos_next = '0;
                                rd_addr  = '0;
                                rv_next  = 1'b1;
                            end
                        end
                        ACT_STATS:
                        begin
                            if (count_reg == '0)
                                odata_next[2:0] = ST_EMPTY;
                            else
                                odata_next = pack(ST_OK, '0, '0, '0, '0, 7'(count_reg),
                                    ta_reg, tv_reg);
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // Read of idx-1 lands now; write it to idx, or place the new entry.
                if (idx_reg == pos_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pos_reg[AW-1:0];
                    wr_data = {prc_reg[23:0], amt_reg[23:0], key_reg};
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_reg - 1'b1;
                    rd_addr  = AW'(idx_reg - 2'd2);
                end
                s_axis_tready = 1'b0;
            end
            S_SHIFT_DN:
            begin
                // Read of idx+1 lands now; move it down until idx reaches the new count.
                if (idx_reg < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = AW'(idx_reg + 2'd2);
                end
            end
            S_LIST:
            begin
                rd_addr = pos_reg[AW-1:0];
                rv_next = rv_reg;
                if (ofree && rv_reg)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = (pos_reg + 1'b1 >= count_reg);
                    odata_next  = pack(ST_OK, rk, ra, rp, 6'(pos_reg), 7'(count_reg), '0, '0);
                    pos_next = pos_reg + 1'b1;
                    rd_addr  = AW'(pos_reg + 1'b1);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
endmodule

[rtl/skt_checker.sv]
// Port-level checks for the sorted key table, bound to its top level.
`timescale 1ns / 1ps
module skt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import skt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:89] <= 7'd64)
        else $error("entry count out of range");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tlast)
        else $error("error result not marked last");
endmodule

bind sorted_key_table_top skt_checker u_skt_checker (.*);
